// ===== sv/frvm_pkg.sv =====
// shared types, opcodes and constants for the four register machine
// no dependencies

package frvm_pkg;

    localparam int REG_COUNT_DEF = 4;
    localparam int RAM_WORDS_DEF = 65536;
    localparam int WORD_W        = 32;
    localparam int FIELD_W       = 8;

    typedef enum logic [7:0] {
        OP_HALT = 8'd0,
        OP_NOP  = 8'd1,
        OP_LI   = 8'd2,
        OP_LW   = 8'd3,
        OP_SW   = 8'd4,
        OP_ADD  = 8'd5,
        OP_SUB  = 8'd6,
        OP_MULT = 8'd7,
        OP_DIV  = 8'd8,
        OP_J    = 8'd9,
        OP_JR   = 8'd10,
        OP_BEQ  = 8'd11,
        OP_BNE  = 8'd12,
        OP_INC  = 8'd13,
        OP_DEC  = 8'd14
    } opcode_t;

    // decoded instruction class carried through the queue
    typedef enum logic [3:0] {
        K_NOP, K_HALT, K_LI, K_LW, K_SW, K_ADD, K_SUB, K_MULT, K_DIV,
        K_J, K_JR, K_BEQ, K_BNE, K_INC, K_DEC
    } kind_t;

    typedef enum logic [2:0] {
        EX_IDLE, EX_READ, EX_MUL, EX_DIV, EX_CLEAR, EX_OUT
    } ex_state_t;

    typedef struct packed {
        kind_t             kind;
        logic [FIELD_W-1:0] d;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        logic [WORD_W-1:0]  imm;
    } instr_t;

    typedef struct packed {
        logic start;
        logic a_neg;
        logic b_neg;
    } div_ctl_t;

endpackage

// ===== sv/frvm_front.sv =====
// front end: accepts instruction transactions, classifies them, two-entry queue
// depends on frvm_pkg

module frvm_front
    import frvm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         operation,
    input  logic [7:0]         dest_reg,
    input  logic [7:0]         src_a_reg,
    input  logic [7:0]         src_b_reg,
    input  logic [31:0]        immediate,
    output logic               q_valid,
    input  logic               q_pop,
    output instr_t             q_head
);

    instr_t      slot_reg [2];
    logic        rd_ptr_reg, rd_ptr_next, wr_ptr_reg, wr_ptr_next;
    logic [1:0]  count_reg, count_next;
    kind_t       kind;
    logic        push;

    always_comb
    begin
        unique case (operation)
            OP_HALT: kind = K_HALT;
            OP_LI:   kind = K_LI;
            OP_LW:   kind = K_LW;
            OP_SW:   kind = K_SW;
            OP_ADD:  kind = K_ADD;
            OP_SUB:  kind = K_SUB;
            OP_MULT: kind = K_MULT;
            OP_DIV:  kind = K_DIV;
            OP_J:    kind = K_J;
            OP_JR:   kind = K_JR;
            OP_BEQ:  kind = K_BEQ;
            OP_BNE:  kind = K_BNE;
            OP_INC:  kind = K_INC;
            OP_DEC:  kind = K_DEC;
            default: kind = K_NOP;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_head   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= '{kind, dest_reg, src_a_reg, src_b_reg, immediate};
    end

endmodule

// ===== sv/frvm_div.sv =====
// iterative signed 32-bit divider, one quotient bit per cycle
// depends on frvm_pkg

module frvm_div
    import frvm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_ctl_t          ctl,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic [WORD_W-1:0] q_reg, q_next, d_reg, d_next;
    logic [WORD_W:0]   r_reg, r_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              neg_reg, neg_next, busy_reg, busy_next, zero_reg, zero_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   shifted;

    always_comb
    begin
        q_next    = q_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        shifted   = {r_reg[WORD_W-1:0], q_reg[WORD_W-1]};
        trial     = shifted - {1'b0, d_reg};
        if (ctl.start)
        begin
            q_next    = ctl.a_neg ? (~dividend + 1'b1) : dividend;
            d_next    = ctl.b_neg ? (~divisor + 1'b1) : divisor;
            r_next    = '0;
            cnt_next  = CNT_W'(WORD_W);
            neg_next  = ctl.a_neg ^ ctl.b_neg;
            zero_next = (divisor == '0);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[WORD_W])
            begin
                r_next = trial;
                q_next = {q_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        d_reg    <= d_next;
        r_reg    <= r_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    assign done     = busy_reg && (cnt_reg == CNT_W'(1));
    assign quotient = zero_reg ? '0 : (neg_reg ? (~q_next + 1'b1) : q_next);

endmodule

// ===== sv/frvm_back.sv =====
// back end: register file, data RAM, program counter, result register
// depends on frvm_pkg, frvm_div

module frvm_back
    import frvm_pkg::*;
#(
    parameter int REGISTER_COUNT = REG_COUNT_DEF,
    parameter int RAM_WORDS      = RAM_WORDS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  instr_t              q_head,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         next_pc,
    output logic                halted,
    output logic signed [31:0]  reg0_value,
    output logic signed [31:0]  reg1_value,
    output logic signed [31:0]  reg2_value,
    output logic signed [31:0]  reg3_value
);

    localparam int RI_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam int AW   = $clog2(RAM_WORDS);

    ex_state_t         st_reg, st_next;
    logic [WORD_W-1:0] rf_reg [REGISTER_COUNT];
    logic [WORD_W-1:0] mem [RAM_WORDS];
    logic [WORD_W-1:0] pc_reg, mem_q_reg, prod_reg;
    logic              halt_reg, ov_reg;
    logic [AW-1:0]     clr_reg;
    logic [31:0]       o_pc_reg;
    logic              o_halt_reg;
    logic [WORD_W-1:0] o_r_reg [4];
    logic [RI_W-1:0]   di, ai, bi;
    logic [WORD_W-1:0] rd, ra, rb, wval, pc_new;
    logic              wen, finish, mem_we, clr_go;
    logic [AW-1:0]     mem_addr;
    div_ctl_t          dctl;
    logic              ddone;
    logic [WORD_W-1:0] dq;

    function automatic logic [RI_W-1:0] ridx(input logic [FIELD_W-1:0] f);
        return RI_W'(32'(f) % REGISTER_COUNT);
    endfunction

    assign di = ridx(q_head.d);
    assign ai = ridx(q_head.a);
    assign bi = ridx(q_head.b);
    assign rd = rf_reg[di];
    assign ra = rf_reg[ai];
    assign rb = rf_reg[bi];
    assign mem_addr = ra[AW-1:0];

    assign dctl = '{start: (st_reg == EX_IDLE) && q_valid && !ov_reg && !halt_reg
                           && q_head.kind == K_DIV,
                    a_neg: ra[WORD_W-1], b_neg: rb[WORD_W-1]};

    frvm_div u_div (.clk, .rst_n, .ctl(dctl), .dividend(ra), .divisor(rb),
                    .done(ddone), .quotient(dq));

    always_comb
    begin
        st_next = st_reg;
        q_pop   = 1'b0;
        finish  = 1'b0;
        mem_we  = 1'b0;
        clr_go  = 1'b0;
        unique case (st_reg)
            EX_CLEAR:
            begin
                clr_go = 1'b1;
                if (clr_reg == AW'(RAM_WORDS - 1))
                    st_next = EX_IDLE;
            end
            EX_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    if (halt_reg)
                        finish = 1'b1;
                    else
                    begin
                        unique case (q_head.kind)
                            K_LW:    st_next = EX_READ;
                            K_MULT:  st_next = EX_MUL;
                            K_DIV:   st_next = EX_DIV;
                            default:
                            begin
                                finish = 1'b1;
                                mem_we = (q_head.kind == K_SW);
                            end
                        endcase
                    end
                end
            end
            EX_READ, EX_MUL:
            begin
                finish  = 1'b1;
                st_next = EX_IDLE;
            end
            EX_DIV:
            begin
                if (ddone)
                begin
                    finish  = 1'b1;
                    st_next = EX_IDLE;
                end
            end
            default: st_next = EX_IDLE;
        endcase
        q_pop = finish;
    end

    always_comb
    begin
        wen    = 1'b0;
        wval   = rd;
        pc_new = pc_reg + 1'b1;
        unique case (q_head.kind)
            K_LI:   begin wen = 1'b1; wval = q_head.imm; end
            K_LW:   begin wen = 1'b1; wval = mem_q_reg; end
            K_ADD:  begin wen = 1'b1; wval = ra + rb; end
            K_SUB:  begin wen = 1'b1; wval = ra - rb; end
            K_MULT: begin wen = 1'b1; wval = prod_reg; end
            K_DIV:  begin wen = 1'b1; wval = dq; end
            K_INC:  begin wen = 1'b1; wval = rd + 1'b1; end
            K_DEC:  begin wen = 1'b1; wval = rd - 1'b1; end
            K_J:    pc_new = q_head.imm;
            K_JR:   pc_new = rd;
            K_BEQ:  if (rd == ra) pc_new = rb;
            K_BNE:  if (rd != ra) pc_new = rb;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= EX_CLEAR;
            clr_reg  <= '0;
            pc_reg   <= '0;
            halt_reg <= 1'b0;
            ov_reg   <= 1'b0;
            for (int i = 0; i < REGISTER_COUNT; i++)
                rf_reg[i] <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (clr_go)
                clr_reg <= clr_reg + 1'b1;
            if (finish)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            if (finish && !halt_reg)
            begin
                pc_reg <= pc_new;
                if (q_head.kind == K_HALT)
                    halt_reg <= 1'b1;
                if (wen)
                    rf_reg[di] <= wval;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_go)
            mem[clr_reg] <= '0;
        else if (mem_we)
            mem[mem_addr] <= rd;
        mem_q_reg <= mem[mem_addr];
        prod_reg  <= ra * rb;
        if (finish)
        begin
            o_pc_reg   <= halt_reg ? pc_reg : pc_new;
            o_halt_reg <= halt_reg || (q_head.kind == K_HALT);
            for (int j = 0; j < 4; j++)
            begin
                if (j >= REGISTER_COUNT)
                    o_r_reg[j] <= '0;
                else if (!halt_reg && wen && int'(di) == j)
                    o_r_reg[j] <= wval;
                else
                    o_r_reg[j] <= rf_reg[(j < REGISTER_COUNT) ? j : 0];
            end
        end
    end

    assign out_valid  = ov_reg;
    assign next_pc    = o_pc_reg;
    assign halted     = o_halt_reg;
    assign reg0_value = o_r_reg[0];
    assign reg1_value = o_r_reg[1];
    assign reg2_value = o_r_reg[2];
    assign reg3_value = o_r_reg[3];

endmodule

// ===== sv/four_register_vm_execute.sv =====
// top level of the four register machine: front queue plus execute back end
// depends on frvm_pkg, frvm_front, frvm_back, frvm_div
//
// channel  dir  handshake              payload
// input    in   in_valid / in_ready    operation dest_reg src_a_reg src_b_reg immediate
// output   out  out_valid / out_ready  next_pc halted reg0..reg3_value
//
// lw and mult go through EX_READ / EX_MUL, div waits in EX_DIV (one quotient bit a cycle)
// after reset a clearing pass runs over all RAM_WORDS words of the data RAM first
// the front queue holds two transactions and keeps taking them while results wait, until it is full

module four_register_vm_execute
    import frvm_pkg::*;
#(
    parameter int REGISTER_COUNT = REG_COUNT_DEF,
    parameter int RAM_WORDS      = RAM_WORDS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         operation,
    input  logic [7:0]         dest_reg,
    input  logic [7:0]         src_a_reg,
    input  logic [7:0]         src_b_reg,
    input  logic [31:0]        immediate,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        next_pc,
    output logic               halted,
    output logic signed [31:0] reg0_value,
    output logic signed [31:0] reg1_value,
    output logic signed [31:0] reg2_value,
    output logic signed [31:0] reg3_value
);

    logic   q_valid, q_pop;
    instr_t q_head;

    frvm_front u_front (.clk, .rst_n, .in_valid, .in_ready, .operation, .dest_reg,
                        .src_a_reg, .src_b_reg, .immediate, .q_valid, .q_pop, .q_head);

    frvm_back #(.REGISTER_COUNT(REGISTER_COUNT), .RAM_WORDS(RAM_WORDS)) u_back (
        .clk, .rst_n, .q_valid, .q_pop, .q_head, .out_valid, .out_ready, .next_pc,
        .halted, .reg0_value, .reg1_value, .reg2_value, .reg3_value);

    a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");

    a_no_pop_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !q_pop) else $error("result overwritten");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && halted) |=> (!out_valid || halted)) else $error("halt cleared");

endmodule
